[sv/gct_pkg.sv]
// ----------------------------------------------------------------------------
// gct_pkg: shared types and constants of the grid collision table
// Holds the table size, slot tags, operation and status codes, and the
// structures that travel between the ring of entry cells and the control.
// ----------------------------------------------------------------------------
package gct_pkg;

  localparam int Capacity = 256;
  localparam int CNT_W = $clog2(Capacity);

  localparam logic [15:0] TAG_CORNER = 16'hFFFE;
  localparam logic [15:0] TAG_CROSS  = 16'hFFFF;
  localparam logic [15:0] TAG_CONN   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOGIC = 2'd0,
    OP_WIRE  = 2'd1,
    OP_COLL  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    IT_BODY      = 3'd0,
    IT_ELEM_CONN = 3'd1,
    IT_WIRE_CONN = 3'd2,
    IT_HOR       = 3'd3,
    IT_VER       = 3'd4,
    IT_CORNER    = 3'd5,
    IT_CROSS     = 3'd6,
    IT_NEW       = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNEXPECTED = 3'd1,
    ST_OCCUPIED   = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_TYPE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CL_ELEM_BODY  = 4'd0,
    CL_ELEM_CONN  = 4'd1,
    CL_WIRE_CONN  = 4'd2,
    CL_WIRE_HOR   = 4'd3,
    CL_WIRE_VER   = 4'd4,
    CL_CORNER     = 4'd5,
    CL_CROSS      = 4'd6,
    CL_CROSSING   = 4'd7,
    CL_ELEM_WIRE  = 4'd8,
    CL_INVALID    = 4'd9
  } class_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_CREATE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_DECIDE = 3'd2,
    S_WRITE  = 3'd3,
    S_HOLD   = 3'd4
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] body;
    logic [15:0] hor;
    logic [15:0] ver;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic        has_free;
    logic [15:0] body;
    logic [15:0] hor;
    logic [15:0] ver;
  } lookup_t;

  typedef struct packed {
    status_t     status;
    logic        colliding;
    class_t      cls;
    logic [15:0] body;
    logic [15:0] hor;
    logic [15:0] ver;
    logic [15:0] first;
  } result_t;

  typedef struct packed {
    result_t     res;
    action_t     action;
    logic [15:0] new_body;
    logic [15:0] new_hor;
    logic [15:0] new_ver;
  } decision_t;

endpackage

[sv/gct_if.sv]
// ----------------------------------------------------------------------------
// gct_if: channel interfaces of the grid collision table
// One interface for the operation channel and one for the result channel,
// each with valid/ready handshake and its payload.
// ----------------------------------------------------------------------------
interface gct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic [2:0]  kind;
  logic [15:0] old_id;
  logic [15:0] new_id;

  modport source (output valid, operation, point_x, point_y, kind, old_id, new_id,
                  input ready);
  modport sink (input valid, operation, point_x, point_y, kind, old_id, new_id,
                output ready);
endinterface

interface gct_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        colliding;
  logic [3:0]  state_class;
  logic [15:0] body_slot;
  logic [15:0] horizontal_slot;
  logic [15:0] vertical_slot;
  logic [15:0] first_wire;

  modport source (output valid, status, colliding, state_class, body_slot,
                  horizontal_slot, vertical_slot, first_wire, input ready);
  modport sink (input valid, status, colliding, state_class, body_slot,
                horizontal_slot, vertical_slot, first_wire, output ready);
endinterface

[sv/gct_cell.sv]
// ----------------------------------------------------------------------------
// gct_cell: one table entry in the rotating ring
// Holds one entry and passes it to the next cell whenever the ring shifts.
// Flags whether its entry is valid and carries the point being looked up.
// ----------------------------------------------------------------------------
module gct_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  logic [31:0]      query_key,
  input  gct_pkg::entry_t  d,
  output gct_pkg::entry_t  q,
  output logic             hit
);

  logic        valid_r;
  logic [31:0] key_r;
  logic [15:0] body_r;
  logic [15:0] hor_r;
  logic [15:0] ver_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r  <= d.key;
      body_r <= d.body;
      hor_r  <= d.hor;
      ver_r  <= d.ver;
    end
  end

  assign q   = '{valid: valid_r, key: key_r, body: body_r, hor: hor_r, ver: ver_r};
  assign hit = valid_r && (key_r == query_key);

endmodule

[sv/gct_rules.sv]
// ----------------------------------------------------------------------------
// gct_rules: update, collision and classification rules
// Applies the tag and id checks of one operation to the looked-up slots and
// decides the status, the result slots and the write-back action.
// ----------------------------------------------------------------------------
module gct_rules (
  input  gct_pkg::op_t        op,
  input  gct_pkg::kind_t      kind,
  input  logic [15:0]         old_id,
  input  logic [15:0]         new_id,
  input  gct_pkg::lookup_t    lk,
  output gct_pkg::decision_t  dec
);

  function automatic logic elem_body(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b != 16'd0) && (h == 16'd0) && (v == 16'd0);
  endfunction
  function automatic logic elem_conn(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b != 16'd0) && (h == 16'd0) && (v == gct_pkg::TAG_CONN);
  endfunction
  function automatic logic wire_conn(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b == 16'd0) && (h != 16'd0) && (v == gct_pkg::TAG_CONN);
  endfunction
  function automatic logic wire_hor(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b == 16'd0) && (h != 16'd0) && (v == 16'd0);
  endfunction
  function automatic logic wire_ver(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b == 16'd0) && (h == 16'd0) && (v != 16'd0);
  endfunction
  function automatic logic crossing(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b == 16'd0) && (h != 16'd0) && (v != 16'd0);
  endfunction
  function automatic logic elem_wire(logic [15:0] b, logic [15:0] h, logic [15:0] v);
    return (b != 16'd0) && (h != 16'd0) && (v == gct_pkg::TAG_CONN);
  endfunction

  logic [15:0]          b, h, v, nb, nh, nv, tag, rb, rh, rv;
  logic                 coll, rfound, empty;
  gct_pkg::status_t     st;
  gct_pkg::action_t     act;
  gct_pkg::class_t      cls;

  always_comb begin
    b    = lk.found ? lk.body : 16'd0;
    h    = lk.found ? lk.hor  : 16'd0;
    v    = lk.found ? lk.ver  : 16'd0;
    nb   = b;
    nh   = h;
    nv   = v;
    st   = gct_pkg::ST_OK;
    coll = 1'b0;
    tag  = (kind == gct_pkg::IT_CORNER) ? gct_pkg::TAG_CORNER : gct_pkg::TAG_CROSS;

    case (op)
      gct_pkg::OP_LOGIC: begin
        case (kind)
          gct_pkg::IT_BODY: begin
            if (nb != old_id) st = gct_pkg::ST_UNEXPECTED;
            else nb = new_id;
          end
          gct_pkg::IT_ELEM_CONN: begin
            if (nv != 16'd0 && nv != gct_pkg::TAG_CONN) begin
              st = gct_pkg::ST_OCCUPIED;
            end else begin
              nv = gct_pkg::TAG_CONN;
              if (nb != old_id) st = gct_pkg::ST_UNEXPECTED;
              else nb = new_id;
            end
          end
          default: st = gct_pkg::ST_BAD_TYPE;
        endcase
      end
      gct_pkg::OP_WIRE: begin
        case (kind)
          gct_pkg::IT_WIRE_CONN: begin
            if (nv != 16'd0 && nv != gct_pkg::TAG_CONN) begin
              st = gct_pkg::ST_OCCUPIED;
            end else begin
              nv = gct_pkg::TAG_CONN;
              if (nh != old_id) st = gct_pkg::ST_UNEXPECTED;
              else nh = new_id;
            end
          end
          gct_pkg::IT_HOR: begin
            if (nh != old_id) st = gct_pkg::ST_UNEXPECTED;
            else nh = new_id;
          end
          gct_pkg::IT_VER: begin
            if (nv != old_id) st = gct_pkg::ST_UNEXPECTED;
            else nv = new_id;
          end
          gct_pkg::IT_CORNER, gct_pkg::IT_CROSS: begin
            if (nb != 16'd0 && nb != tag) begin
              st = gct_pkg::ST_OCCUPIED;
            end else begin
              nb = tag;
              if (nh != old_id) begin
                st = gct_pkg::ST_UNEXPECTED;
              end else begin
                nh = new_id;
                if (nv != old_id) st = gct_pkg::ST_UNEXPECTED;
                else nv = new_id;
              end
            end
          end
          default: st = gct_pkg::ST_BAD_TYPE;
        endcase
      end
      gct_pkg::OP_COLL: begin
        case (kind)
          gct_pkg::IT_ELEM_CONN: coll = !wire_conn(b, h, v);
          gct_pkg::IT_WIRE_CONN: coll = !elem_conn(b, h, v);
          gct_pkg::IT_HOR:       coll = !wire_ver(b, h, v);
          gct_pkg::IT_VER:       coll = !wire_hor(b, h, v);
          gct_pkg::IT_NEW:       coll = elem_body(b, h, v) || elem_wire(b, h, v) ||
                                        crossing(b, h, v);
          default:               coll = 1'b1;
        endcase
        coll = coll && lk.found;
      end
      default: ;
    endcase

    // An entry without any id left is freed rather than written.
    empty = (nb == 16'd0 || nb == gct_pkg::TAG_CORNER || nb == gct_pkg::TAG_CROSS) &&
            (nh == 16'd0) && (nv == 16'd0 || nv == gct_pkg::TAG_CONN);
    act    = gct_pkg::ACT_NONE;
    rfound = lk.found;
    rb     = b;
    rh     = h;
    rv     = v;
    if ((op == gct_pkg::OP_LOGIC || op == gct_pkg::OP_WIRE) && st == gct_pkg::ST_OK) begin
      if (empty) begin
        act    = lk.found ? gct_pkg::ACT_FREE : gct_pkg::ACT_NONE;
        rfound = 1'b0;
        rb     = 16'd0;
        rh     = 16'd0;
        rv     = 16'd0;
      end else if (lk.found || lk.has_free) begin
        act    = lk.found ? gct_pkg::ACT_UPDATE : gct_pkg::ACT_CREATE;
        rfound = 1'b1;
        rb     = nb;
        rh     = nh;
        rv     = nv;
      end else begin
        st = gct_pkg::ST_FULL;
      end
    end

    if (!rfound) cls = gct_pkg::CL_INVALID;
    else if (elem_body(rb, rh, rv)) cls = gct_pkg::CL_ELEM_BODY;
    else if (elem_conn(rb, rh, rv)) cls = gct_pkg::CL_ELEM_CONN;
    else if (wire_conn(rb, rh, rv)) cls = gct_pkg::CL_WIRE_CONN;
    else if (wire_hor(rb, rh, rv)) cls = gct_pkg::CL_WIRE_HOR;
    else if (wire_ver(rb, rh, rv)) cls = gct_pkg::CL_WIRE_VER;
    else if (rb == gct_pkg::TAG_CORNER && rh != 16'd0 && rh == rv) cls = gct_pkg::CL_CORNER;
    else if (rb == gct_pkg::TAG_CROSS && rh != 16'd0 && rh == rv) cls = gct_pkg::CL_CROSS;
    else if (crossing(rb, rh, rv)) cls = gct_pkg::CL_CROSSING;
    else if (elem_wire(rb, rh, rv)) cls = gct_pkg::CL_ELEM_WIRE;
    else cls = gct_pkg::CL_INVALID;

    dec = '{res: '{status: st, colliding: coll, cls: cls, body: rb, hor: rh, ver: rv,
                   first: (rh != 16'd0) ? rh : rv},
            action: act, new_body: nb, new_hor: nh, new_ver: nv};
  end

endmodule

[sv/grid_collision_table.sv]
// ----------------------------------------------------------------------------
// grid_collision_table: table of grid points and the items that occupy them
// Keeps up to Capacity points, each with a body, a horizontal-wire and a
// vertical-wire slot, and runs update, collision-check and read operations.
// ----------------------------------------------------------------------------
// The entries live in a ring of Capacity cells that rotates by one cell per
// clock during the search and write-back turns; the control looks at the
// entry leaving the last cell. An operation searches the ring in one full
// turn, applies the rules in the decision state, and, when an update
// changes, creates or frees an entry, writes it back in a second turn,
// after which the result is registered. One operation is in flight at a
// time; a new transaction is taken in the cycle after the previous
// operation has finished. A finished result waits in the output register
// without blocking the next transaction; an operation that finishes while
// that register is still occupied holds, with the ring at rest, until the
// waiting result has been handed off. The table is empty after reset, with
// no clearing pass, since each cell's valid flag resets at once.
module grid_collision_table (
  input  logic       clk,
  input  logic       rst_n,
  gct_in_if.sink     in_ch,
  gct_out_if.source  out_ch
);

  // Operation being worked on, captured when the transaction is accepted.
  gct_pkg::op_t        op_r;
  gct_pkg::kind_t      type_r;
  logic [31:0]         key_r;
  logic [15:0]         old_r;
  logic [15:0]         new_r;

  gct_pkg::state_t     state_r, state_nxt;
  logic [gct_pkg::CNT_W-1:0] cnt_r;
  logic                cnt_last;

  // Search results collected while the ring turns.
  logic                found_r;
  logic                free_r;
  logic [15:0]         lb_r, lh_r, lv_r;
  logic                claimed_r;

  gct_pkg::decision_t  dec, dec_r;
  gct_pkg::lookup_t    lk;

  // Result handed to the output register when an operation finishes.
  gct_pkg::result_t    done_res;
  gct_pkg::result_t    out_res_r;

  logic                out_valid_r;
  logic                out_free;
  logic                accept;
  logic                shift;
  logic                done;

  gct_pkg::entry_t     chain [gct_pkg::Capacity];
  logic                hits  [gct_pkg::Capacity];
  gct_pkg::entry_t     tail;
  logic                tail_hit;
  gct_pkg::entry_t     ring_in;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == gct_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_last = (cnt_r == gct_pkg::CNT_W'(gct_pkg::Capacity - 1));
  assign shift    = (state_r == gct_pkg::S_SCAN) || (state_r == gct_pkg::S_WRITE);
  assign tail     = chain[gct_pkg::Capacity-1];
  assign tail_hit = hits[gct_pkg::Capacity-1];

  // The ring closes through the write-back path: during the write turn the
  // entry of the point is updated or freed, or the first free cell is
  // claimed for a new point.
  always_comb begin
    ring_in = tail;
    if (state_r == gct_pkg::S_WRITE) begin
      case (dec_r.action)
        gct_pkg::ACT_UPDATE: begin
          if (tail_hit) begin
            ring_in.body = dec_r.new_body;
            ring_in.hor  = dec_r.new_hor;
            ring_in.ver  = dec_r.new_ver;
          end
        end
        gct_pkg::ACT_FREE: begin
          if (tail_hit) ring_in.valid = 1'b0;
        end
        gct_pkg::ACT_CREATE: begin
          if (!tail.valid && !claimed_r) begin
            ring_in = '{valid: 1'b1, key: key_r, body: dec_r.new_body,
                        hor: dec_r.new_hor, ver: dec_r.new_ver};
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < gct_pkg::Capacity; k++) begin : g_ring
    gct_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (shift),
      .query_key (key_r),
      .d         ((k == 0) ? ring_in : chain[(k == 0) ? 0 : k - 1]),
      .q         (chain[k]),
      .hit       (hits[k])
    );
  end

  assign lk = '{found: found_r, has_free: free_r, body: lb_r, hor: lh_r, ver: lv_r};

  gct_rules u_rules (
    .op     (op_r),
    .kind   (type_r),
    .old_id (old_r),
    .new_id (new_r),
    .lk     (lk),
    .dec    (dec)
  );

  // A result that leaves straight from the decision comes from the rules;
  // after a write turn it comes from the registered decision.
  assign done_res = (state_r == gct_pkg::S_DECIDE) ? dec.res : dec_r.res;

  // Sequencer: search turn, decision, optional write turn, and a hold while
  // the output register is still occupied.
  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    case (state_r)
      gct_pkg::S_IDLE:   if (accept) state_nxt = gct_pkg::S_SCAN;
      gct_pkg::S_SCAN:   if (cnt_last) state_nxt = gct_pkg::S_DECIDE;
      gct_pkg::S_DECIDE: begin
        if (dec.action == gct_pkg::ACT_NONE) begin
          if (out_free) begin
            state_nxt = gct_pkg::S_IDLE;
            done      = 1'b1;
          end
        end else begin
          state_nxt = gct_pkg::S_WRITE;
        end
      end
      gct_pkg::S_WRITE: begin
        if (cnt_last) begin
          if (out_free) begin
            state_nxt = gct_pkg::S_IDLE;
            done      = 1'b1;
          end else begin
            state_nxt = gct_pkg::S_HOLD;
          end
        end
      end
      gct_pkg::S_HOLD: begin
        if (out_free) begin
          state_nxt = gct_pkg::S_IDLE;
          done      = 1'b1;
        end
      end
      default: state_nxt = gct_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gct_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (shift) begin
        cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= done_res;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= gct_pkg::op_t'(in_ch.operation);
      type_r    <= gct_pkg::kind_t'(in_ch.kind);
      key_r     <= {in_ch.point_x, in_ch.point_y};
      old_r     <= in_ch.old_id;
      new_r     <= in_ch.new_id;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      claimed_r <= 1'b0;
    end else if (state_r == gct_pkg::S_SCAN) begin
      if (tail_hit) begin
        found_r <= 1'b1;
        lb_r    <= tail.body;
        lh_r    <= tail.hor;
        lv_r    <= tail.ver;
      end
      if (!tail.valid) free_r <= 1'b1;
    end else if (state_r == gct_pkg::S_WRITE) begin
      if (dec_r.action == gct_pkg::ACT_CREATE && !tail.valid) claimed_r <= 1'b1;
    end
    if (state_r == gct_pkg::S_DECIDE) begin
      dec_r <= dec;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.colliding       = out_res_r.colliding;
  assign out_ch.state_class     = out_res_r.cls;
  assign out_ch.body_slot       = out_res_r.body;
  assign out_ch.horizontal_slot = out_res_r.hor;
  assign out_ch.vertical_slot   = out_res_r.ver;
  assign out_ch.first_wire      = out_res_r.first;

`ifndef SYNTHESIS
  // A new operation is only taken while the ring is idle, and it always
  // starts a search turn.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == gct_pkg::S_SCAN)
    else $error("accepted transaction did not start a search");

  // The turn counter is back at zero whenever the ring is at rest, so each
  // turn rotates the ring exactly once.
  a_cnt_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gct_pkg::S_IDLE || state_r == gct_pkg::S_DECIDE ||
     state_r == gct_pkg::S_HOLD) |-> cnt_r == '0)
    else $error("ring turn counter out of step");

  // A full-table status is only given when the search saw no free cell.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == gct_pkg::ST_FULL) |-> !free_r)
    else $error("table full reported with a free cell");

  // A create claims a free cell by the end of its write turn.
  a_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gct_pkg::S_WRITE && cnt_last && dec_r.action == gct_pkg::ACT_CREATE)
      |=> claimed_r)
    else $error("new entry was not placed");
`endif

endmodule

[sim/grid_collision_table_test.sv]
// ----------------------------------------------------------------------------
// grid_collision_table_test: self-checking bench of the grid collision table
// Drives logic, wire, collision and read transactions through the operation
// channel. A behavioral copy of the table predicts every result, and each
// result transaction is compared field by field, in order.
// ----------------------------------------------------------------------------
module grid_collision_table_test;

  // One operation as the bench sees it.
  typedef struct {
    gct_pkg::op_t   op;
    logic [15:0]    x;
    logic [15:0]    y;
    gct_pkg::kind_t typ;
    logic [15:0]    old_id;
    logic [15:0]    new_id;
  } table_op_t;

  // One result transaction.
  typedef struct {
    gct_pkg::status_t status;
    logic             colliding;
    gct_pkg::class_t  cls;
    logic [15:0]      body;
    logic [15:0]      hor;
    logic [15:0]      ver;
    logic [15:0]      first;
  } table_reply_t;

  localparam int PERIOD = 20;
  // A table-changing update takes a search turn, the decision and a write turn.
  localparam int OP_LATENCY = 2 * gct_pkg::Capacity + 1;

  logic clk;
  logic rst_n;

  gct_in_if  in_ch();
  gct_out_if out_ch();

  grid_collision_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the table, updated when an operation is accepted.
  logic        shadow_valid [gct_pkg::Capacity];
  logic [31:0] shadow_key   [gct_pkg::Capacity];
  logic [15:0] shadow_body  [gct_pkg::Capacity];
  logic [15:0] shadow_hor   [gct_pkg::Capacity];
  logic [15:0] shadow_ver   [gct_pkg::Capacity];

  table_reply_t pending_replies[$];

  int mismatches = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int receiver_hold_cycles = 0;

  // The clock runs with a 20-unit period.
  always begin
    clk = 1'b1;
    #(PERIOD / 2);
    clk = 1'b0;
    #(PERIOD / 2);
  end

  // The whole run is bounded: about 1500 operations, plus stalls and the long
  // hold-off, fit well within the watchdog below.
  initial begin
    #(PERIOD * 4000000);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Classifies an entry by its three slots.
  function automatic gct_pkg::class_t entry_class(logic [15:0] b, logic [15:0] h,
                                                  logic [15:0] v);
    if (b != 0 && h == 0 && v == 0) return gct_pkg::CL_ELEM_BODY;
    if (b != 0 && h == 0 && v == gct_pkg::TAG_CONN) return gct_pkg::CL_ELEM_CONN;
    if (b == 0 && h != 0 && v == gct_pkg::TAG_CONN) return gct_pkg::CL_WIRE_CONN;
    if (b == 0 && h != 0 && v == 0) return gct_pkg::CL_WIRE_HOR;
    if (b == 0 && h == 0 && v != 0) return gct_pkg::CL_WIRE_VER;
    if (b == gct_pkg::TAG_CORNER && h != 0 && v != 0 && h == v) return gct_pkg::CL_CORNER;
    if (b == gct_pkg::TAG_CROSS && h != 0 && v != 0 && h == v) return gct_pkg::CL_CROSS;
    if (b == 0 && h != 0 && v != 0) return gct_pkg::CL_CROSSING;
    if (b != 0 && h != 0 && v == gct_pkg::TAG_CONN) return gct_pkg::CL_ELEM_WIRE;
    return gct_pkg::CL_INVALID;
  endfunction

  // Tells whether an item of the given type would collide with an entry.
  function automatic logic collides(gct_pkg::kind_t t, logic [15:0] b, logic [15:0] h,
                                    logic [15:0] v);
    gct_pkg::class_t c;
    c = entry_class(b, h, v);
    case (t)
      gct_pkg::IT_ELEM_CONN: return c != gct_pkg::CL_WIRE_CONN;
      gct_pkg::IT_WIRE_CONN: return c != gct_pkg::CL_ELEM_CONN;
      gct_pkg::IT_HOR:       return !(b == 0 && h == 0 && v != 0);
      gct_pkg::IT_VER:       return !(b == 0 && h != 0 && v == 0);
      gct_pkg::IT_NEW:       return (b != 0 && h == 0 && v == 0) ||
                                    (b != 0 && h != 0 && v == gct_pkg::TAG_CONN) ||
                                    (b == 0 && h != 0 && v != 0);
      default:               return 1'b1;
    endcase
  endfunction

  // Number of live entries in the shadow table.
  function automatic int live_entries();
    int n;
    n = 0;
    foreach (shadow_valid[i]) if (shadow_valid[i]) n++;
    return n;
  endfunction

  // Finds the slots of a point, all zero when it has no entry.
  function automatic void peek_point(logic [15:0] x, logic [15:0] y, output logic [15:0] b,
                                     output logic [15:0] h, output logic [15:0] v);
    b = 0;
    h = 0;
    v = 0;
    for (int i = 0; i < gct_pkg::Capacity; i++) begin
      if (shadow_valid[i] && shadow_key[i] == {x, y}) begin
        b = shadow_body[i];
        h = shadow_hor[i];
        v = shadow_ver[i];
        return;
      end
    end
  endfunction

  // Applies one operation to the shadow table and returns the reply it causes.
  function automatic table_reply_t apply_table_op(table_op_t it);
    table_reply_t r;
    int idx, free_idx;
    logic found, has_free, empty;
    logic [15:0] b, h, v, nb, nh, nv;
    gct_pkg::status_t st;

    idx = 0;
    free_idx = 0;
    found = 0;
    has_free = 0;
    b = 0;
    h = 0;
    v = 0;
    st = gct_pkg::ST_OK;
    for (int i = 0; i < gct_pkg::Capacity; i++) begin
      if (shadow_valid[i]) begin
        if (!found && shadow_key[i] == {it.x, it.y}) begin
          found = 1;
          idx = i;
        end
      end else if (!has_free) begin
        has_free = 1;
        free_idx = i;
      end
    end
    if (found) begin
      b = shadow_body[idx];
      h = shadow_hor[idx];
      v = shadow_ver[idx];
    end
    nb = b;
    nh = h;
    nv = v;
    r.colliding = 1'b0;

    if (it.op == gct_pkg::OP_LOGIC) begin
      // A connection tag goes into the vertical slot before the body id check.
      if (it.typ == gct_pkg::IT_ELEM_CONN) begin
        if (nv != 0 && nv != gct_pkg::TAG_CONN) st = gct_pkg::ST_OCCUPIED;
        else nv = gct_pkg::TAG_CONN;
      end else if (it.typ != gct_pkg::IT_BODY) begin
        st = gct_pkg::ST_BAD_TYPE;
      end
      if (st == gct_pkg::ST_OK) begin
        if (nb != it.old_id) st = gct_pkg::ST_UNEXPECTED;
        else nb = it.new_id;
      end
    end else if (it.op == gct_pkg::OP_WIRE) begin
      case (it.typ)
        gct_pkg::IT_WIRE_CONN: begin
          if (nv != 0 && nv != gct_pkg::TAG_CONN) st = gct_pkg::ST_OCCUPIED;
          else nv = gct_pkg::TAG_CONN;
          if (st == gct_pkg::ST_OK) begin
            if (nh != it.old_id) st = gct_pkg::ST_UNEXPECTED;
            else nh = it.new_id;
          end
        end
        gct_pkg::IT_HOR: begin
          if (nh != it.old_id) st = gct_pkg::ST_UNEXPECTED;
          else nh = it.new_id;
        end
        gct_pkg::IT_VER: begin
          if (nv != it.old_id) st = gct_pkg::ST_UNEXPECTED;
          else nv = it.new_id;
        end
        gct_pkg::IT_CORNER, gct_pkg::IT_CROSS: begin
          // The point tag is checked first, then horizontal, then vertical.
          logic [15:0] tag;
          tag = (it.typ == gct_pkg::IT_CORNER) ? gct_pkg::TAG_CORNER : gct_pkg::TAG_CROSS;
          if (nb != 0 && nb != tag) st = gct_pkg::ST_OCCUPIED;
          else nb = tag;
          if (st == gct_pkg::ST_OK) begin
            if (nh != it.old_id) st = gct_pkg::ST_UNEXPECTED;
            else nh = it.new_id;
          end
          if (st == gct_pkg::ST_OK) begin
            if (nv != it.old_id) st = gct_pkg::ST_UNEXPECTED;
            else nv = it.new_id;
          end
        end
        default: st = gct_pkg::ST_BAD_TYPE;
      endcase
    end else if (it.op == gct_pkg::OP_COLL) begin
      r.colliding = found && collides(it.typ, b, h, v);
    end

    if ((it.op == gct_pkg::OP_LOGIC || it.op == gct_pkg::OP_WIRE) &&
        st == gct_pkg::ST_OK) begin
      // An entry that holds no real id any more is freed.
      empty = (nb == 0 || nb == gct_pkg::TAG_CORNER || nb == gct_pkg::TAG_CROSS) &&
              nh == 0 && (nv == 0 || nv == gct_pkg::TAG_CONN);
      if (empty) begin
        if (found) shadow_valid[idx] = 1'b0;
        found = 0;
        b = 0;
        h = 0;
        v = 0;
      end else if (found || has_free) begin
        if (!found) begin
          idx = free_idx;
          shadow_valid[idx] = 1'b1;
          shadow_key[idx] = {it.x, it.y};
          found = 1;
        end
        shadow_body[idx] = nb;
        shadow_hor[idx] = nh;
        shadow_ver[idx] = nv;
        b = nb;
        h = nh;
        v = nv;
      end else begin
        st = gct_pkg::ST_FULL;
      end
    end

    r.status = st;
    r.cls = found ? entry_class(b, h, v) : gct_pkg::CL_INVALID;
    r.body = b;
    r.hor = h;
    r.ver = v;
    r.first = (h != 0) ? h : v;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Offers one operation after a random idle gap, and predicts its result once
  // the block takes the transaction. Valid stays high on return so that a
  // following operation can go out back to back.
  task automatic send_op(table_op_t it);
    table_reply_t r;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = it.op;
    in_ch.point_x   = it.x;
    in_ch.point_y   = it.y;
    in_ch.kind      = it.typ;
    in_ch.old_id    = it.old_id;
    in_ch.new_id    = it.new_id;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_table_op(it);
    pending_replies.insert(pending_replies.size(), r);
  endtask

  task automatic send_fields(gct_pkg::op_t op, logic [15:0] x, logic [15:0] y,
                             gct_pkg::kind_t t, logic [15:0] old_id, logic [15:0] new_id);
    table_op_t it;
    it.op = op;
    it.x = x;
    it.y = y;
    it.typ = t;
    it.old_id = old_id;
    it.new_id = new_id;
    send_op(it);
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_replies.size() == 0);
  endtask

  task automatic compare_field(string name, logic [15:0] expected, logic [15:0] actual);
    if (expected !== actual) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s: expected %0d, got %0d", name, expected, actual);
    end
  endtask

  // The receiver draws its ready at every falling edge; a hold-off keeps it
  // low for a counted number of cycles.
  always @(negedge clk) begin
    if (receiver_hold_cycles > 0) begin
      receiver_hold_cycles <= receiver_hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    table_reply_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result transaction with no operation pending");
      end else begin
        exp_r = pending_replies.pop_front();
        compare_field("status", 16'(exp_r.status), 16'(out_ch.status));
        compare_field("colliding", 16'(exp_r.colliding), 16'(out_ch.colliding));
        compare_field("state_class", 16'(exp_r.cls), 16'(out_ch.state_class));
        compare_field("body_slot", exp_r.body, out_ch.body_slot);
        compare_field("horizontal_slot", exp_r.hor, out_ch.horizontal_slot);
        compare_field("vertical_slot", exp_r.ver, out_ch.vertical_slot);
        compare_field("first_wire", exp_r.first, out_ch.first_wire);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme coordinates, every operation, bad types, tag conflicts, id
  // mismatches, freeing and the missing-entry answers.
  task automatic test_directed();
    send_fields(gct_pkg::OP_READ, 16'h8000, 16'h7FFF, gct_pkg::IT_BODY, 0, 0);
    send_fields(gct_pkg::OP_COLL, 16'h8000, 16'h7FFF, gct_pkg::IT_BODY, 0, 0);
    send_fields(gct_pkg::OP_LOGIC, 16'h8000, 16'h7FFF, gct_pkg::IT_BODY, 0, 16'd65532);
    send_fields(gct_pkg::OP_LOGIC, 16'h8000, 16'h7FFF, gct_pkg::IT_WIRE_CONN,
                16'd65532, 1);
    send_fields(gct_pkg::OP_WIRE, 16'h8000, 16'h7FFF, gct_pkg::IT_BODY, 0, 1);
    send_fields(gct_pkg::OP_WIRE, 16'h8000, 16'h7FFF, gct_pkg::IT_NEW, 0, 1);
    send_fields(gct_pkg::OP_LOGIC, 16'h8000, 16'h7FFF, gct_pkg::IT_ELEM_CONN,
                16'd65532, 16'd65532);
    send_fields(gct_pkg::OP_COLL, 16'h8000, 16'h7FFF, gct_pkg::IT_WIRE_CONN, 0, 0);
    send_fields(gct_pkg::OP_COLL, 16'h8000, 16'h7FFF, gct_pkg::IT_NEW, 0, 0);
    send_fields(gct_pkg::OP_WIRE, 16'h8000, 16'h7FFF, gct_pkg::IT_WIRE_CONN, 0, 16'd21845);
    send_fields(gct_pkg::OP_READ, 16'h8000, 16'h7FFF, gct_pkg::IT_NEW, 0, 0);
    // Corner point, then a cross tag on it is refused as occupied.
    send_fields(gct_pkg::OP_WIRE, 16'h7FFF, 16'h8000, gct_pkg::IT_CORNER, 0, 16'd43690);
    send_fields(gct_pkg::OP_WIRE, 16'h7FFF, 16'h8000, gct_pkg::IT_CROSS,
                16'd43690, 16'd43690);
    send_fields(gct_pkg::OP_WIRE, 16'h7FFF, 16'h8000, gct_pkg::IT_HOR, 16'd5, 16'd6);
    send_fields(gct_pkg::OP_COLL, 16'h7FFF, 16'h8000, gct_pkg::IT_HOR, 0, 0);
    send_fields(gct_pkg::OP_WIRE, 16'h7FFF, 16'h8000, gct_pkg::IT_VER, 16'd43690, 0);
    send_fields(gct_pkg::OP_WIRE, 16'h7FFF, 16'h8000, gct_pkg::IT_HOR, 16'd43690, 0);
    send_fields(gct_pkg::OP_READ, 16'h7FFF, 16'h8000, gct_pkg::IT_BODY, 0, 0);
    // A body update that leaves nothing frees the entry; an empty update of a
    // missing point stays missing.
    send_fields(gct_pkg::OP_WIRE, 16'h8000, 16'h7FFF, gct_pkg::IT_WIRE_CONN, 16'd21845, 0);
    send_fields(gct_pkg::OP_LOGIC, 16'h8000, 16'h7FFF, gct_pkg::IT_BODY, 16'd65532, 0);
    send_fields(gct_pkg::OP_READ, 16'h8000, 16'h7FFF, gct_pkg::IT_BODY, 0, 0);
    send_fields(gct_pkg::OP_LOGIC, 16'h0000, 16'h0000, gct_pkg::IT_BODY, 0, 0);
    drain();
  endtask

  // Fills every entry, checks the full status and that errors and empty
  // updates still win over it, then frees the fill again.
  task automatic test_table_full();
    int n;
    n = 0;
    while (live_entries() < gct_pkg::Capacity) begin
      send_fields(gct_pkg::OP_WIRE, 16'(1000 + n), 16'(-n), gct_pkg::IT_HOR, 0,
                  16'(n + 1));
      n++;
    end
    send_fields(gct_pkg::OP_WIRE, 16'h4000, 16'h4000, gct_pkg::IT_VER, 0, 16'd77);
    send_fields(gct_pkg::OP_WIRE, 16'h4000, 16'h4000, gct_pkg::IT_VER, 16'd3, 16'd77);
    send_fields(gct_pkg::OP_LOGIC, 16'h4000, 16'h4000, gct_pkg::IT_BODY, 0, 0);
    send_fields(gct_pkg::OP_WIRE, 16'h4000, 16'h4000, gct_pkg::IT_NEW, 0, 16'd77);
    send_fields(gct_pkg::OP_READ, 16'h4000, 16'h4000, gct_pkg::IT_BODY, 0, 0);
    for (int i = 0; i < n; i++)
      send_fields(gct_pkg::OP_WIRE, 16'(1000 + i), 16'(-i), gct_pkg::IT_HOR,
                  16'(i + 1), 0);
    drain();
  endtask

  // Random operations, mostly on a small set of points with the ids that the
  // table holds, so that updates succeed and entries go through every class.
  task automatic test_random(int count);
    table_op_t it;
    logic [15:0] b, h, v;
    int pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 88 || live_entries() > 200) begin
        it.x = 16'($signed($urandom_range(6)) - 3);
        it.y = 16'($signed($urandom_range(3)) - 1);
      end else begin
        it.x = 16'($urandom);
        it.y = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 28) it.op = gct_pkg::OP_LOGIC;
      else if (pick < 68) it.op = gct_pkg::OP_WIRE;
      else if (pick < 84) it.op = gct_pkg::OP_COLL;
      else it.op = gct_pkg::OP_READ;
      if ($urandom_range(9) == 0) it.typ = gct_pkg::kind_t'($urandom_range(7));
      else if (it.op == gct_pkg::OP_LOGIC) it.typ = gct_pkg::kind_t'($urandom_range(1));
      else if (it.op == gct_pkg::OP_WIRE) it.typ = gct_pkg::kind_t'($urandom_range(6, 2));
      else it.typ = gct_pkg::kind_t'($urandom_range(7));
      peek_point(it.x, it.y, b, h, v);
      if ($urandom_range(99) < 80) begin
        case (it.typ)
          gct_pkg::IT_BODY, gct_pkg::IT_ELEM_CONN: it.old_id = b;
          gct_pkg::IT_VER:                         it.old_id = v;
          default:                                 it.old_id = h;
        endcase
        if (it.old_id > 16'd65532) it.old_id = 0;
      end else begin
        it.old_id = 16'($urandom_range(65532));
      end
      pick = $urandom_range(99);
      if (pick < 30) it.new_id = 0;
      else if (pick < 60) it.new_id = 16'($urandom_range(20, 1));
      else it.new_id = 16'($urandom_range(65532, 1));
      send_op(it);
    end
  endtask

  // Holds the receiver off for a long stretch while operations keep coming,
  // then pauses the sender until the table has answered everything.
  task automatic test_backpressure();
    receiver_hold_cycles = 3000;
    test_random(12);
    drain();
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = gct_pkg::OP_LOGIC;
    in_ch.point_x = 0;
    in_ch.point_y = 0;
    in_ch.kind = gct_pkg::IT_BODY;
    in_ch.old_id = 0;
    in_ch.new_id = 0;
    out_ch.ready = 1'b0;
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_backpressure();

    // Random traffic in several idling phases, the first with none at all.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random(240);
    sender_idle_pct = 73;
    receiver_stall_pct = 0;
    test_random(220);
    sender_idle_pct = 0;
    receiver_stall_pct = 73;
    test_random(220);
    sender_idle_pct = 9;
    receiver_stall_pct = 9;
    test_random(220);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random(40);

    drain();
    repeat (OP_LATENCY + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[grid_collision_table.f]
sv/gct_pkg.sv
sv/gct_if.sv
sv/gct_cell.sv
sv/gct_rules.sv
sv/grid_collision_table.sv
sim/grid_collision_table_test.sv
